// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/fct_pkg.sv -----
`timescale 1ns / 1ps

package fct_pkg;

  localparam int IV_W    = 32;
  localparam int PREV_W  = 27;
  localparam int SCORE_W = 9;
  localparam int PRED_W  = 32;
  localparam int VB_W    = 30;
  localparam int DEV_W   = 8;

  localparam logic [IV_W-1:0]    MIN_INTERVAL   = 32'd2000000;
  localparam logic [IV_W-1:0]    MAX_INTERVAL   = 32'd100000000;
  localparam logic [SCORE_W-1:0] STABLE_LEVEL   = 9'd224;
  localparam logic [SCORE_W-1:0] FULL_SCORE     = 9'd256;
  localparam logic [SCORE_W-1:0] NEUTRAL_SCORE  = 9'd128;
  localparam logic [24:0]        MIN_PREDICTION = 25'd100000;
  localparam logic [VB_W-1:0]    VBLANK_RESET   = 30'd16666666;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CMP,
    ST_DIV,
    ST_SCORE,
    ST_PRED_MAG,
    ST_PRED_DELTA,
    ST_PRED_ADD,
    ST_CLAMP,
    ST_FINISH
  } fct_state_t;

  typedef struct packed {
    logic              start;
    logic [PREV_W-1:0] num;
    logic [PREV_W-1:0] den;
  } fct_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DEV_W-1:0] quo;
  } fct_div_rsp_t;

endpackage

// ----- design/fct_div.sv -----
`timescale 1ns / 1ps

module fct_div
  import fct_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  fct_div_req_t req,
  output fct_div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DEV_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PREV_W:0]   rem_r;
  logic [PREV_W-1:0] den_r;
  logic [DEV_W-1:0]  quo_r;
  logic [PREV_W:0]   rem_sh;
  logic              fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r[PREV_W-1:0], 1'b0};
    fits   = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DEV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= {1'b0, req.num};
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_r <= {quo_r[DEV_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- design/frame_cadence_and_render_time_tracker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// frame cadence and render time tracker
// in channel: one item per completed frame; in_tdata carries the
// presentation interval and the measured render time, in_tuser flags that
// the render time is valid
// out channel: one item per input item with the stability score, the
// stable flag and the predicted render time
// cfg port: cfg_wr_en writes the refresh period; write only while idle
// steps: an accepted item goes through the check and prediction steps; a
// valid interval after a valid one adds the compare and score steps, and the
// bit-serial divider (one quotient bit per cycle) when the deviation is
// below the previous interval; updating an existing prediction adds the
// delta, add and clamp steps; one item is handled at a time, and the next
// item can be accepted in the cycle after the previous result is loaded
// reset: stability 128, no previous interval, no prediction, refresh
// period 16666666 ns
// stall: a result waits in the output register while out_tready is low;
// a following item is processed up to its final step and then held until
// the output register frees

module frame_cadence_and_render_time_tracker
  import fct_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [63:0]     in_tdata,   // interval_ns, render_ns
  input  logic            in_tuser,   // render_valid
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [47:0]     out_tdata,  // stability, stable, predicted_render_ns
  input  logic            cfg_wr_en,
  input  logic [VB_W-1:0] cfg_wr_data
);

  fct_state_t state_r, state_nxt;

  logic [VB_W-1:0]    vb_r;
  logic [IV_W-1:0]    iv_r;
  logic               rv_r;
  logic [PRED_W-1:0]  rn_r;
  logic [PREV_W-1:0]  prev_r;
  logic [PREV_W-1:0]  prev_old_r;
  logic [PREV_W-1:0]  diff_r;
  logic [SCORE_W-1:0] sample_r;
  logic [SCORE_W-1:0] stab_r;
  logic [PRED_W-1:0]  pred_r;
  logic               rise_r;
  logic [PRED_W-1:0]  mag_r;
  logic [PRED_W:0]    delta_r;
  logic [PRED_W:0]    upd_r;
  logic               out_valid_r;
  logic [47:0]        out_data_r;

  fct_div_req_t div_req;
  fct_div_rsp_t div_rsp;

  logic [11:0]        score_up;
  logic [SCORE_W:0]   score_dn;
  logic [SCORE_W-1:0] score_new;
  logic [9:0]         s_prod;
  logic [2:0]         s_val;
  logic [4:0]         s_mask;
  logic [PRED_W:0]    d_sum;
  logic [PRED_W:0]    d_shift;
  logic [24:0]        lo_val;
  logic [PRED_W-1:0]  hi_val;
  logic               iv_bad;
  logic               load_out;

  fct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    iv_bad    = (iv_r < MIN_INTERVAL) || (iv_r > MAX_INTERVAL);
    score_up  = {stab_r, 3'b000} - 12'(stab_r) + 12'(sample_r);
    score_dn  = ({1'b0, stab_r} + {1'b0, sample_r}) >> 1;
    score_new = (sample_r > stab_r) ? score_up[11:3] : score_dn[SCORE_W-1:0];
    s_prod    = {stab_r, 1'b0} + 10'(stab_r);
    s_val     = 3'd1 + 3'(s_prod[9:8]);
    s_mask    = (5'd1 << s_val) - 5'd1;
    if (rise_r) begin
      d_sum   = {1'b0, mag_r} + 33'd1;
      d_shift = (s_val > 3'd2) ? (d_sum >> 2) : (d_sum >> 1);
    end else begin
      d_sum   = {1'b0, mag_r} + 33'(s_mask);
      d_shift = d_sum >> s_val;
    end
    lo_val = (25'(vb_r >> 5) < MIN_PREDICTION) ? MIN_PREDICTION : 25'(vb_r >> 5);
    hi_val = {vb_r, 2'b00};
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    load_out      = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = diff_r;
    div_req.den   = prev_old_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (iv_bad || prev_r == '0) begin
          state_nxt = ST_PRED_MAG;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (diff_r >= prev_old_r) begin
          state_nxt = ST_SCORE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SCORE;
        end
      end
      ST_SCORE:      state_nxt = ST_PRED_MAG;
      ST_PRED_MAG: begin
        if (!rv_r || rn_r == '0 || pred_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_PRED_DELTA;
        end
      end
      ST_PRED_DELTA: state_nxt = ST_PRED_ADD;
      ST_PRED_ADD:   state_nxt = ST_CLAMP;
      ST_CLAMP:      state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r        <= VBLANK_RESET;
      prev_r      <= '0;
      stab_r      <= NEUTRAL_SCORE;
      pred_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vb_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CHECK: begin
          if (iv_bad) begin
            stab_r <= NEUTRAL_SCORE;
            prev_r <= '0;
          end else begin
            prev_r <= iv_r[PREV_W-1:0];
          end
        end
        ST_SCORE: stab_r <= score_new;
        ST_PRED_MAG: begin
          if (rv_r && rn_r != '0 && pred_r == '0) begin
            pred_r <= rn_r;
          end
        end
        ST_CLAMP: begin
          if (upd_r < 33'(lo_val)) begin
            pred_r <= 32'(lo_val);
          end else if (upd_r > {1'b0, hi_val}) begin
            pred_r <= hi_val;
          end else begin
            pred_r <= upd_r[PRED_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      iv_r <= in_tdata[31:0];
      rn_r <= in_tdata[63:32];
      rv_r <= in_tuser;
    end
    if (state_r == ST_CHECK) begin
      prev_old_r <= prev_r;
      diff_r     <= (iv_r[PREV_W-1:0] > prev_r) ? iv_r[PREV_W-1:0] - prev_r
                                                : prev_r - iv_r[PREV_W-1:0];
    end
    if (state_r == ST_CMP) begin
      sample_r <= '0;
    end
    if (state_r == ST_DIV && div_rsp.done) begin
      sample_r <= FULL_SCORE - {1'b0, div_rsp.quo};
    end
    if (state_r == ST_PRED_MAG) begin
      rise_r <= rn_r > pred_r;
      mag_r  <= (rn_r > pred_r) ? rn_r - pred_r : pred_r - rn_r;
    end
    if (state_r == ST_PRED_DELTA) begin
      delta_r <= d_shift;
    end
    if (state_r == ST_PRED_ADD) begin
      upd_r <= rise_r ? {1'b0, pred_r} + delta_r : {1'b0, pred_r} - delta_r;
    end
    if (load_out) begin
      out_data_r <= {6'b000000, pred_r, stab_r >= STABLE_LEVEL, stab_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_rsp.done, state_r == ST_DIV)
  `ASSERT_SAME(a_stab_range, clk, rst_n, 1'b1, stab_r <= FULL_SCORE)
  `ASSERT_NEXT(a_accept_check, clk, rst_n, in_tvalid && in_tready, state_r == ST_CHECK)

endmodule

// ----- tb/tb_frame_cadence_and_render_time_tracker.sv -----
`timescale 1ns / 1ps

module tb_frame_cadence_and_render_time_tracker;
  import fct_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASES         = 6;
  localparam int PHASE_FRAMES   = 255;

  typedef struct packed {
    logic [SCORE_W-1:0] stability;
    logic               stable;
    logic [PRED_W-1:0]  predicted;
  } frame_result_t;

  class cadence_scoreboard;
    logic [VB_W-1:0]    refresh_ns;
    logic [PREV_W-1:0]  last_interval;
    logic [SCORE_W-1:0] score;
    logic [PRED_W-1:0]  prediction;
    frame_result_t      expected_results[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        frames;
    int unsigned        out_of_range;
    int unsigned        render_updates;

    function new();
      refresh_ns     = VBLANK_RESET;
      last_interval  = '0;
      score          = NEUTRAL_SCORE;
      prediction     = '0;
      mismatches     = 0;
      checked        = 0;
      frames         = 0;
      out_of_range   = 0;
      render_updates = 0;
    endfunction

    function void set_refresh(logic [VB_W-1:0] v);
      refresh_ns = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_frame(logic [31:0] iv, logic rv, logic [31:0] rn);
      logic [63:0]   diff;
      logic [63:0]   dev;
      logic [63:0]   cur;
      logic [63:0]   meas;
      logic [63:0]   upd;
      logic [63:0]   mag;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [31:0]   sample;
      logic [31:0]   mix;
      logic [31:0]   shift_s;
      frame_result_t r;
      frames++;
      // cadence stability
      if (iv < MIN_INTERVAL || iv > MAX_INTERVAL) begin
        score         = NEUTRAL_SCORE;
        last_interval = '0;
        out_of_range++;
      end else begin
        if (last_interval != '0) begin
          cur  = {37'd0, last_interval};
          diff = ({32'd0, iv} > cur) ? {32'd0, iv} - cur : cur - {32'd0, iv};
          dev  = (diff << 8) / cur;
          sample = (dev >= 64'd256) ? 32'd0 : 32'd256 - dev[31:0];
          if (sample > {23'd0, score}) begin
            mix = ({23'd0, score} * 32'd7 + sample) >> 3;
          end else begin
            mix = ({23'd0, score} + sample) >> 1;
          end
          score = mix[SCORE_W-1:0];
        end
        last_interval = iv[PREV_W-1:0];
      end
      // render time prediction with the new score
      if (rv && rn != '0) begin
        render_updates++;
        if (prediction == '0) begin
          prediction = rn;
        end else begin
          shift_s = 32'd1 + (({23'd0, score} * 32'd3) >> 8);
          cur     = {32'd0, prediction};
          meas    = {32'd0, rn};
          if (meas > cur) begin
            upd = cur + ((meas - cur + 64'd1) >> ((shift_s > 32'd2) ? 2 : 1));
          end else begin
            mag = cur - meas;
            upd = cur - ((mag + (64'd1 << shift_s) - 64'd1) >> shift_s);
          end
          lo = {34'd0, refresh_ns} >> 5;
          if (lo < {39'd0, MIN_PREDICTION}) begin
            lo = {39'd0, MIN_PREDICTION};
          end
          hi = {34'd0, refresh_ns} << 2;
          if (upd < lo) begin
            upd = lo;
          end else if (upd > hi) begin
            upd = hi;
          end
          prediction = upd[PRED_W-1:0];
        end
      end
      r.stability = score;
      r.stable    = (score >= STABLE_LEVEL);
      r.predicted = prediction;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [47:0] data);
      frame_result_t want;
      frame_result_t got;
      got.stability = data[8:0];
      got.stable    = data[9];
      got.predicted = data[41:10];
      if (expected_results.size() == 0) begin
        $display("%0t: result %h arrived with no frame pending", $time, data);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      if (got.stability !== want.stability) begin
        $display("%0t: stability expected %0d actual %0d", $time, want.stability,
                 got.stability);
        mismatches++;
      end
      if (got.stable !== want.stable) begin
        $display("%0t: stable expected %0d actual %0d", $time, want.stable, got.stable);
        mismatches++;
      end
      if (got.predicted !== want.predicted) begin
        $display("%0t: predicted render expected %0d actual %0d", $time, want.predicted,
                 got.predicted);
        mismatches++;
      end
    endfunction
  endclass

  logic            clk         = 1'b0;
  logic            rst_n       = 1'b0;
  logic            in_tvalid   = 1'b0;
  logic            in_tready;
  logic [63:0]     in_tdata    = '0;   // interval_ns, render_ns
  logic            in_tuser    = 1'b0; // render_valid
  logic            out_tvalid;
  logic            out_tready  = 1'b0;
  logic [47:0]     out_tdata;          // stability, stable, predicted_render_ns
  logic            cfg_wr_en   = 1'b0;
  logic [VB_W-1:0] cfg_wr_data = '0;

  cadence_scoreboard sb;
  logic              hold_req  = 1'b0;
  logic              quiet     = 1'b0;
  logic              gaps_on   = 1'b0;
  logic              stalls_on = 1'b0;
  int unsigned       idle_count = 0;
  int unsigned       refresh_writes = 0;
  logic [VB_W-1:0]   refresh_plan [0:PHASES-1];

  frame_cadence_and_render_time_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_frame(in_tdata[31:0], in_tuser, in_tdata[63:32]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_count);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && stalls_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_frame(logic [31:0] iv, logic rv, logic [31:0] rn);
    int unsigned gap;
    if (!quiet && gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {rn, iv};
    in_tuser  <= rv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every frame has its result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_refresh(logic [VB_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_refresh(v);
    refresh_writes++;
  endtask

  task automatic run_frames(int unsigned count, logic [VB_W-1:0] vb, int phase_no);
    longint unsigned lo_band;
    longint unsigned hi_band;
    longint unsigned base;
    longint unsigned jit;
    longint unsigned rb;
    longint unsigned rn64;
    int unsigned     seq_left;
    int unsigned     k;
    logic [31:0]     iv;
    logic [31:0]     rn;
    logic            rv;
    seq_left = 0;
    base     = 16_666_666;
    rb       = 1;
    k        = 8;
    for (int unsigned i = 0; i < count; i++) begin
      if (phase_no == 1 && i == 40) begin
        hold_req = 1'b1;
      end
      if (phase_no == 2 && i == count / 2) begin
        settle();
      end
      // a run of frames at a steady cadence with one render-time level
      if (seq_left == 0) begin
        seq_left = $urandom_range(8, 60);
        if ($urandom_range(0, 3) == 0) begin
          base = $urandom_range(2_000_000, 100_000_000);
        end else begin
          base = $urandom_range(2_000_000, 60_000_000);
        end
        k       = $urandom_range(3, 12);
        lo_band = longint'(vb) >> 5;
        if (lo_band < MIN_PREDICTION) begin
          lo_band = MIN_PREDICTION;
        end
        hi_band = longint'(vb) << 2;
        case ($urandom_range(0, 3))
          0: rb = $urandom_range(1, 32'(lo_band));
          1: rb = hi_band + $urandom_range(0, 32'(hi_band / 2));
          default: rb = $urandom_range(32'(lo_band), 32'(hi_band));
        endcase
        if (rb > 64'hFFFF_FFFF) begin
          rb = 64'hFFFF_FFFF;
        end
        gaps_on   = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      seq_left--;
      jit  = base >> k;
      iv   = 32'(base - jit + $urandom_range(0, 32'(2 * jit)));
      rv   = ($urandom_range(0, 7) != 0);
      rn64 = rb - (rb >> 4) + $urandom_range(0, 32'(rb >> 3));
      if (rn64 > 64'hFFFF_FFFF) begin
        rn64 = 64'hFFFF_FFFF;
      end
      rn = rn64[31:0];
      case ($urandom_range(0, 24))
        0: iv = $urandom();
        1: iv = MIN_INTERVAL - $urandom_range(0, 1);
        2: iv = MAX_INTERVAL + $urandom_range(0, 1);
        3: rn = '0;
        4: rn = $urandom();
        default: ;
      endcase
      send_frame(iv, rv, rn);
    end
  endtask

  initial begin
    sb = new();
    refresh_plan[0] = 30'd1_000_000;
    refresh_plan[1] = 30'd1_000_000_000;
    refresh_plan[2] = 30'd6_944_444;
    refresh_plan[3] = 30'd20_000;      // floor above ceiling
    refresh_plan[4] = 30'd33_333_333;
    refresh_plan[5] = 30'd16_666_666;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames at the reset refresh period
    stalls_on = 1'b1;
    send_frame(32'd0, 1'b1, 32'd0);
    send_frame(MIN_INTERVAL - 32'd1, 1'b0, 32'd5_000_000);
    send_frame(MIN_INTERVAL, 1'b1, 32'd80_000_000);
    send_frame(MAX_INTERVAL, 1'b1, 32'd9_000_000);
    send_frame(MAX_INTERVAL + 32'd1, 1'b1, 32'd1);
    send_frame(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 12; i++) begin
      send_frame(32'd16_666_666 + i * 200, 1'b1, i[0] ? 32'd20_000_000 : 32'd3_000_000);
    end
    send_frame(MAX_INTERVAL, 1'b1, 32'd7_000_000);
    send_frame(MIN_INTERVAL, 1'b1, 32'd7_000_000);
    send_frame(MIN_INTERVAL, 1'b0, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_refresh(refresh_plan[p]);
      quiet = (p == PHASES - 1);
      run_frames(PHASE_FRAMES, refresh_plan[p], p);
    end
    settle();

    $display("covered %0d frames over %0d refresh period writes, %0d out-of-range intervals",
             sb.frames, refresh_writes, sb.out_of_range);
    $display("%0d render samples applied, %0d results checked, %0d mismatches",
             sb.render_updates, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- frame_cadence_and_render_time_tracker.f -----
+incdir+design
design/fct_pkg.sv
design/fct_div.sv
design/frame_cadence_and_render_time_tracker.sv
tb/tb_frame_cadence_and_render_time_tracker.sv
